FILE: hdl/kmae_pkg.sv
// Shared types, constants, keymaps and escape expansion for the key matrix encoder.
package kmae_pkg;

    localparam int NUM_KEYS = 40;
    localparam int KEY_W    = 6;

    localparam logic [KEY_W-1:0] KEY_CAPS = KEY_W'(4);
    localparam logic [KEY_W-1:0] KEY_SYM  = KEY_W'(38);
    localparam logic [KEY_W-1:0] KEY_BRK  = KEY_W'(39);
    localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(NUM_KEYS - 1);

    localparam logic [7:0] BRK_CODE  = 8'h05;
    localparam logic [7:0] CHAR_ESC  = 8'h1b;
    localparam logic [7:0] CHAR_LBR  = 8'h5b;
    localparam logic [7:0] CHAR_TILD = 8'h7e;

    localparam logic [1:0] CFG_INIT_DELAY = 2'd0;
    localparam logic [1:0] CFG_REP_INT    = 2'd1;
    localparam logic [1:0] CFG_RAW_MODE   = 2'd2;

    localparam logic [6:0] RST_INIT_DELAY = 7'd30;
    localparam logic [6:0] RST_REP_INT    = 7'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAYER,
        S_WALK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic       update;
        logic       shift;
        logic [7:0] thr;
        logic [6:0] rep;
    } t_cell_ctl;

    typedef struct packed {
        logic            kind;
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } t_emit;

    localparam logic [7:0] MAP0 [NUM_KEYS] = '{
        8'h76, 8'h63, 8'h78, 8'h7a, 8'h01, 8'h67, 8'h66, 8'h64, 8'h73, 8'h61,
        8'h74, 8'h72, 8'h65, 8'h77, 8'h71, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31,
        8'h36, 8'h37, 8'h38, 8'h39, 8'h30, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70,
        8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h0a, 8'h62, 8'h6e, 8'h6d, 8'h02, 8'h20
    };
    localparam logic [7:0] MAP1 [NUM_KEYS] = '{
        8'h56, 8'h43, 8'h58, 8'h5a, 8'h01, 8'h47, 8'h46, 8'h44, 8'h53, 8'h41,
        8'h54, 8'h52, 8'h45, 8'h57, 8'h51, 8'h25, 8'h24, 8'h23, 8'h40, 8'h21,
        8'h26, 8'h27, 8'h28, 8'h29, 8'h5f, 8'h59, 8'h55, 8'h49, 8'h4f, 8'h50,
        8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h0a, 8'h42, 8'h4e, 8'h4d, 8'h02, 8'h05
    };
    localparam logic [7:0] MAP2 [NUM_KEYS] = '{
        8'h2f, 8'h3f, 8'h78, 8'h3a, 8'h01, 8'h7d, 8'h7b, 8'h5c, 8'h7c, 8'h7e,
        8'h3e, 8'h3c, 8'h65, 8'h77, 8'h09, 8'h85, 8'h34, 8'h33, 8'h60, 8'h81,
        8'h86, 8'h87, 8'h88, 8'h39, 8'h08, 8'h5b, 8'h5d, 8'h69, 8'h3b, 8'h22,
        8'h5e, 8'h2d, 8'h2b, 8'h3d, 8'h0a, 8'h2a, 8'h2c, 8'h2e, 8'h02, 8'h20
    };
    localparam logic [7:0] MAP3 [NUM_KEYS] = '{
        8'hd6, 8'hc3, 8'hd8, 8'hda, 8'h01, 8'hc7, 8'hc6, 8'hc4, 8'hd3, 8'hc1,
        8'hd4, 8'hd2, 8'hc5, 8'hd7, 8'hd1, 8'hb5, 8'hb4, 8'hb3, 8'hb2, 8'hb1,
        8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hb0, 8'hd9, 8'hd5, 8'hc9, 8'hcf, 8'hd0,
        8'hc8, 8'hca, 8'hcb, 8'hcc, 8'h8a, 8'hc2, 8'hce, 8'hcd, 8'h02, 8'ha0
    };

    function automatic logic [7:0] key_map(input logic [1:0] layer,
                                           input logic [KEY_W-1:0] key);
        logic [7:0] m;
        unique case (layer)
            2'd0:    m = MAP0[key];
            2'd1:    m = MAP1[key];
            2'd2:    m = MAP2[key];
            default: m = MAP3[key];
        endcase
        return m;
    endfunction

    function automatic t_emit emit_of(input logic [7:0] m);
        t_emit e;
        e.kind  = 1'b0;
        e.len   = 3'd1;
        e.bytes = {24'h0, m};
        if (m < 8'h08) begin
            e.len = 3'd0;
        end else if (m[7]) begin
            unique case (m[6:0])
                7'h01:   begin e.len = 3'd2; e.bytes = {16'h0, CHAR_ESC, CHAR_ESC}; end
                7'h05:   begin e.len = 3'd3; e.bytes = {8'h0, 8'h44, CHAR_LBR, CHAR_ESC}; end
                7'h06:   begin e.len = 3'd3; e.bytes = {8'h0, 8'h42, CHAR_LBR, CHAR_ESC}; end
                7'h07:   begin e.len = 3'd3; e.bytes = {8'h0, 8'h41, CHAR_LBR, CHAR_ESC}; end
                7'h08:   begin e.len = 3'd3; e.bytes = {8'h0, 8'h43, CHAR_LBR, CHAR_ESC}; end
                7'h30:   begin e.len = 3'd4; e.bytes = {CHAR_TILD, 8'h33, CHAR_LBR, CHAR_ESC}; end
                7'h35:   begin e.len = 3'd4; e.bytes = {CHAR_TILD, 8'h31, CHAR_LBR, CHAR_ESC}; end
                7'h36:   begin e.len = 3'd4; e.bytes = {CHAR_TILD, 8'h36, CHAR_LBR, CHAR_ESC}; end
                7'h37:   begin e.len = 3'd4; e.bytes = {CHAR_TILD, 8'h35, CHAR_LBR, CHAR_ESC}; end
                7'h38:   begin e.len = 3'd3; e.bytes = {8'h0, 8'h46, CHAR_LBR, CHAR_ESC}; end
                default: begin e.len = 3'd1; end
            endcase
        end
        return e;
    endfunction

endpackage

FILE: hdl/kmae_cell.sv
// One hold-timer cell: updates its timer from its key bit or takes its neighbor's timer.
module kmae_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kmae_pkg::t_cell_ctl i_ctl,
    input  logic                i_key,
    input  logic [7:0]          i_next_timer,
    output logic [7:0]          o_timer
);
    import kmae_pkg::*;

    logic [7:0] r_timer;
    logic [7:0] n_timer;
    logic [7:0] w_inc;

    always_comb begin
        if (!i_key) begin
            w_inc = 8'd0;
        end else if (r_timer == 8'hff) begin
            w_inc = r_timer;
        end else begin
            w_inc = r_timer + 8'd1;
        end
    end

    always_comb begin
        n_timer = r_timer;
        if (i_ctl.update) begin
            n_timer = (w_inc >= i_ctl.thr) ? (w_inc - {1'b0, i_ctl.rep}) : w_inc;
        end else if (i_ctl.shift) begin
            n_timer = i_next_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= 8'd0;
        end else begin
            r_timer <= n_timer;
        end
    end

    assign o_timer = r_timer;

endmodule

FILE: hdl/kmae_chain.sv
// Ring of hold-timer cells that rotates toward cell zero during the key walk.
module kmae_chain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kmae_pkg::t_cell_ctl           i_ctl,
    input  logic [kmae_pkg::NUM_KEYS-1:0] i_keys,
    output logic [7:0]                    o_head,
    output logic [7:0]                    o_caps,
    output logic [7:0]                    o_sym
);
    import kmae_pkg::*;

    logic [7:0] w_timer [NUM_KEYS];

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_cell
        localparam int NEXT = (k + 1) % NUM_KEYS;
        kmae_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_key        (i_keys[k]),
            .i_next_timer (w_timer[NEXT]),
            .o_timer      (w_timer[k])
        );
    end

    assign o_head = w_timer[0];
    assign o_caps = w_timer[KEY_CAPS];
    assign o_sym  = w_timer[KEY_SYM];

endmodule

FILE: hdl/key_matrix_autorepeat_encoder_unit.sv
// Top level of the key matrix scanner with typematic repeat and escape expansion.
//
//  Channel | Direction | Handshake              | Payload
//  in      | sink      | i_in_valid/o_in_ready  | i_key_pressed[39:0]
//  out     | source    | o_out_valid/i_out_ready| o_kind, o_code[7:0], o_last
//  cfg     | sink      | i_cfg_valid/o_cfg_ready| i_cfg_index[1:0], i_cfg_data[6:0]
//
// A scan loads the layer from the caps and symbol timers, then rotates the ring of
// all 40 timer cells past its head cell, holding while later escape bytes go out.
// Raw scans skip layer and walk. A new scan is taken only once the last one is done.
// Reset clears all hold timers at once and restores the register defaults.
// A stalled output holds the walk at a key with bytes due while one result is staged.
module key_matrix_autorepeat_encoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [kmae_pkg::NUM_KEYS-1:0] i_key_pressed,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_kind,
    output logic [7:0]                    o_code,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [6:0]                    i_cfg_data
);
    import kmae_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [6:0]       r_init_delay;
    logic [6:0]       r_rep_int;
    logic             r_raw;
    logic [1:0]       r_layer;
    logic [KEY_W-1:0] r_key_idx;
    logic [1:0]       r_seq_idx;
    logic             r_pend_v;
    logic             r_pend_kind;
    logic [7:0]       r_pend_code;
    logic             r_out_v;
    logic             r_out_kind;
    logic [7:0]       r_out_code;
    logic             r_out_last;

    t_cell_ctl  w_ctl;
    logic [7:0] w_head;
    logic [7:0] w_caps;
    logic [7:0] w_sym;
    logic [7:0] w_map;
    t_emit      w_emit;
    logic       w_fire;
    logic       w_last_byte;
    logic       w_out_free;
    logic       w_can_gen;
    logic       w_accept;
    logic       w_raw_brk;
    logic       w_gen;
    logic       w_advance;
    logic       w_flush_push;
    logic       w_push;

    kmae_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_keys  (i_key_pressed),
        .o_head  (w_head),
        .o_caps  (w_caps),
        .o_sym   (w_sym)
    );

    always_comb begin
        w_map = key_map(r_layer, r_key_idx);
        if (w_map == BRK_CODE) begin
            w_fire = (w_head == 8'd1);
            w_emit = '{kind: 1'b1, len: 3'd1, bytes: '0};
        end else begin
            w_fire = (w_head == 8'd1) || (w_head == {1'b0, r_init_delay});
            w_emit = emit_of(w_map);
        end
        if (!w_fire) begin
            w_emit.len = 3'd0;
        end
        w_last_byte = ({1'b0, r_seq_idx} == (w_emit.len - 3'd1));
    end

    always_comb begin
        w_out_free   = !r_out_v || i_out_ready;
        w_can_gen    = !r_pend_v || w_out_free;
        w_accept     = 1'b0;
        w_raw_brk    = 1'b0;
        w_gen        = 1'b0;
        w_advance    = 1'b0;
        w_flush_push = 1'b0;
        o_in_ready   = 1'b0;
        w_ctl.update = 1'b0;
        w_ctl.shift  = 1'b0;
        w_ctl.thr    = {1'b0, r_init_delay} + {1'b0, r_rep_int};
        w_ctl.rep    = r_rep_int;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                w_accept     = i_in_valid;
                w_ctl.update = w_accept && !r_raw;
                w_raw_brk    = w_accept && r_raw && i_key_pressed[KEY_CAPS]
                               && i_key_pressed[KEY_SYM] && i_key_pressed[KEY_BRK];
            end
            S_LAYER: begin
            end
            S_WALK: begin
                w_gen       = (w_emit.len != 3'd0) && w_can_gen;
                w_advance   = (w_emit.len == 3'd0) || (w_gen && w_last_byte);
                w_ctl.shift = w_advance;
            end
            S_FLUSH: begin
                w_flush_push = r_pend_v && w_out_free;
            end
            default: begin
            end
        endcase
        w_push = (w_gen && r_pend_v) || w_flush_push;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = r_raw ? S_FLUSH : S_LAYER;
                end
            end
            S_LAYER: n_state = S_WALK;
            S_WALK: begin
                if (w_advance && (r_key_idx == KEY_LAST)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_init_delay <= RST_INIT_DELAY;
            r_rep_int    <= RST_REP_INT;
            r_raw        <= 1'b0;
            r_layer      <= 2'd0;
            r_key_idx    <= '0;
            r_seq_idx    <= 2'd0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_INIT_DELAY: r_init_delay <= i_cfg_data;
                    CFG_REP_INT:    r_rep_int    <= i_cfg_data;
                    CFG_RAW_MODE:   r_raw        <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_LAYER) begin
                r_layer <= {w_sym != 8'd0, w_caps != 8'd0};
            end
            if (w_advance) begin
                r_key_idx <= (r_key_idx == KEY_LAST) ? '0 : r_key_idx + KEY_W'(1);
                r_seq_idx <= 2'd0;
            end else if (w_gen) begin
                r_seq_idx <= r_seq_idx + 2'd1;
            end
            if (w_raw_brk || w_gen) begin
                r_pend_v <= 1'b1;
            end else if (w_flush_push) begin
                r_pend_v <= 1'b0;
            end
            if (w_push) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_raw_brk) begin
            r_pend_kind <= 1'b1;
            r_pend_code <= 8'd0;
        end else if (w_gen) begin
            r_pend_kind <= w_emit.kind;
            r_pend_code <= w_emit.bytes[r_seq_idx];
        end
        if (w_push) begin
            r_out_kind <= r_pend_kind;
            r_out_code <= r_pend_code;
            r_out_last <= w_flush_push;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_kind      = r_out_kind;
    assign o_code      = r_out_code;
    assign o_last      = r_out_last;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("staging register holds a result while idle");

    a_idle_ring_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_key_idx == '0))
        else $error("timer ring not back in key order when idle");

    a_seq_only_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_idx != 2'd0) |-> (r_state == S_WALK))
        else $error("escape byte index left set outside the key walk");

    a_push_frees_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!r_out_v || i_out_ready))
        else $error("output register overwritten before its transaction");
`endif

endmodule

FILE: tb/tb_key_matrix_autorepeat_encoder_unit.sv
// Self-checking testbench for the key matrix scanner with typematic repeat and escape output.
module tb_key_matrix_autorepeat_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import kmae_pkg::*;

    localparam int SCAN_CYCLES = 64;
    localparam int STALL_LIMIT = 2000;

    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_BREAK = 1'b1;

    localparam logic [1:0] LAYER_PLAIN   = 2'd0;
    localparam logic [1:0] LAYER_CAPS    = 2'd1;
    localparam logic [1:0] LAYER_SYMBOL  = 2'd2;

    localparam logic [7:0] ESC_BYTE = 8'h1b;
    localparam logic [7:0] LBR_BYTE = 8'h5b;
    localparam logic [7:0] TIL_BYTE = 8'h7e;

    localparam logic [7:0] PLAIN_MAP [NUM_KEYS] = '{
        8'h76, 8'h63, 8'h78, 8'h7a, 8'h01, 8'h67, 8'h66, 8'h64, 8'h73, 8'h61,
        8'h74, 8'h72, 8'h65, 8'h77, 8'h71, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31,
        8'h36, 8'h37, 8'h38, 8'h39, 8'h30, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70,
        8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h0a, 8'h62, 8'h6e, 8'h6d, 8'h02, 8'h20
    };
    localparam logic [7:0] CAPS_MAP [NUM_KEYS] = '{
        8'h56, 8'h43, 8'h58, 8'h5a, 8'h01, 8'h47, 8'h46, 8'h44, 8'h53, 8'h41,
        8'h54, 8'h52, 8'h45, 8'h57, 8'h51, 8'h25, 8'h24, 8'h23, 8'h40, 8'h21,
        8'h26, 8'h27, 8'h28, 8'h29, 8'h5f, 8'h59, 8'h55, 8'h49, 8'h4f, 8'h50,
        8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h0a, 8'h42, 8'h4e, 8'h4d, 8'h02, 8'h05
    };
    localparam logic [7:0] SYMBOL_MAP [NUM_KEYS] = '{
        8'h2f, 8'h3f, 8'h78, 8'h3a, 8'h01, 8'h7d, 8'h7b, 8'h5c, 8'h7c, 8'h7e,
        8'h3e, 8'h3c, 8'h65, 8'h77, 8'h09, 8'h85, 8'h34, 8'h33, 8'h60, 8'h81,
        8'h86, 8'h87, 8'h88, 8'h39, 8'h08, 8'h5b, 8'h5d, 8'h69, 8'h3b, 8'h22,
        8'h5e, 8'h2d, 8'h2b, 8'h3d, 8'h0a, 8'h2a, 8'h2c, 8'h2e, 8'h02, 8'h20
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] code;
        logic       last;
    } t_key_event;

    class keystroke_tracker;
        logic [6:0] first_delay;
        logic [6:0] repeat_step;
        logic       raw_scan;
        logic [7:0] key_hold [NUM_KEYS];
        logic [8:0] scan_bytes [$];
        t_key_event events_due [$];
        int         errors;
        int         scans;
        int         chars_seen;
        int         breaks_seen;

        function new();
            first_delay = 7'd30;
            repeat_step = 7'd5;
            raw_scan    = 1'b0;
            foreach (key_hold[k]) key_hold[k] = 8'd0;
            errors      = 0;
            scans       = 0;
            chars_seen  = 0;
            breaks_seen = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [6:0] value);
            case (index)
                CFG_INIT_DELAY: first_delay = value;
                CFG_REP_INT:    repeat_step = value;
                CFG_RAW_MODE:   raw_scan = value[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] layer_entry(logic [1:0] layer, int k);
            logic [7:0] base;
            base = PLAIN_MAP[k];
            case (layer)
                LAYER_PLAIN:  return base;
                LAYER_CAPS:   return CAPS_MAP[k];
                LAYER_SYMBOL: return SYMBOL_MAP[k];
                default: begin
                    if (base < 8'h08) return base;
                    if (base >= 8'h61 && base <= 8'h7a) return (base - 8'h20) | 8'h80;
                    return base | 8'h80;
                end
            endcase
        endfunction

        function void put_seq(logic [31:0] seq, int n);
            for (int i = 0; i < n; i++) scan_bytes.push_back({KIND_CHAR, seq[31-8*i -: 8]});
        endfunction

        function void send_code(logic [7:0] c);
            if (c < 8'h08) return;
            if (c[7]) begin
                case (c[6:0])
                    7'h01: begin put_seq({ESC_BYTE, ESC_BYTE, 16'h0}, 2); return; end
                    7'h05: begin put_seq({ESC_BYTE, LBR_BYTE, 8'h44, 8'h0}, 3); return; end
                    7'h06: begin put_seq({ESC_BYTE, LBR_BYTE, 8'h42, 8'h0}, 3); return; end
                    7'h07: begin put_seq({ESC_BYTE, LBR_BYTE, 8'h41, 8'h0}, 3); return; end
                    7'h08: begin put_seq({ESC_BYTE, LBR_BYTE, 8'h43, 8'h0}, 3); return; end
                    7'h30: begin put_seq({ESC_BYTE, LBR_BYTE, 8'h33, TIL_BYTE}, 4); return; end
                    7'h35: begin put_seq({ESC_BYTE, LBR_BYTE, 8'h31, TIL_BYTE}, 4); return; end
                    7'h36: begin put_seq({ESC_BYTE, LBR_BYTE, 8'h36, TIL_BYTE}, 4); return; end
                    7'h37: begin put_seq({ESC_BYTE, LBR_BYTE, 8'h35, TIL_BYTE}, 4); return; end
                    7'h38: begin put_seq({ESC_BYTE, LBR_BYTE, 8'h46, 8'h0}, 3); return; end
                    default: ;
                endcase
            end
            scan_bytes.push_back({KIND_CHAR, c});
        endfunction

        function void take_scan(logic [NUM_KEYS-1:0] keys);
            int         thr;
            int         t;
            logic [1:0] layer;
            logic [7:0] m;
            scans++;
            scan_bytes.delete();
            if (raw_scan) begin
                if (keys[KEY_CAPS] && keys[KEY_SYM] && keys[KEY_BRK])
                    scan_bytes.push_back({KIND_BREAK, 8'h00});
            end else begin
                thr = int'(first_delay) + int'(repeat_step);
                for (int k = 0; k < NUM_KEYS; k++) begin
                    t = key_hold[k];
                    if (keys[k]) t = (t < 255) ? t + 1 : t;
                    else t = 0;
                    if (t >= thr) t -= repeat_step;
                    key_hold[k] = t[7:0];
                end
                layer = {key_hold[KEY_SYM] != 8'd0, key_hold[KEY_CAPS] != 8'd0};
                for (int k = 0; k < NUM_KEYS; k++) begin
                    m = layer_entry(layer, k);
                    if (m == BRK_CODE) begin
                        if (key_hold[k] == 8'd1) scan_bytes.push_back({KIND_BREAK, 8'h00});
                    end else if (key_hold[k] == 8'd1 || key_hold[k] == {1'b0, first_delay}) begin
                        send_code(m);
                    end
                end
            end
            foreach (scan_bytes[i]) begin
                events_due.push_back({scan_bytes[i], i == scan_bytes.size() - 1});
                if (scan_bytes[i][8] == KIND_BREAK) breaks_seen++;
                else chars_seen++;
            end
        endfunction

        function void compare_byte(logic kind, logic [7:0] code, logic last);
            t_key_event want;
            if (events_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind %0d code %02h last %0d",
                         $time, kind, code, last);
                return;
            end
            want = events_due.pop_front();
            if (want.kind !== kind) begin
                errors++;
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
            end
            if (want.code !== code) begin
                errors++;
                $display("%0t: code expected %02h actual %02h", $time, want.code, code);
            end
            if (want.last !== last) begin
                errors++;
                $display("%0t: last expected %0d actual %0d", $time, want.last, last);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic [NUM_KEYS-1:0] i_key_pressed = '0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic                o_kind;
    logic [7:0]          o_code;
    logic                o_last;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index   = CFG_INIT_DELAY;
    logic [6:0]          i_cfg_data    = '0;

    keystroke_tracker tracker = new();
    int in_run       = 0;
    int out_run      = 0;
    int settings     = 0;
    int quiet_cycles = 0;

    key_matrix_autorepeat_encoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_key_pressed (i_key_pressed),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_code        (o_code),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_wait(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run = 20;
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    task automatic send_scan(input logic [NUM_KEYS-1:0] keys);
        int gap;
        gap = pick_wait(in_run);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_key_pressed <= keys;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        tracker.take_scan(keys);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.events_due.size() != 0) @(posedge i_clk);
        repeat (SCAN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [6:0] delay, input logic [6:0] step, input logic raw);
        logic [1:0] idx [3];
        logic [6:0] val [3];
        idx = '{CFG_INIT_DELAY, CFG_REP_INT, CFG_RAW_MODE};
        val = '{delay, step, {6'($urandom_range(0, 63)), raw}};
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            @(posedge i_clk);
            while (o_cfg_ready !== 1'b1) @(posedge i_clk);
            tracker.write_reg(idx[i], val[i]);
        end
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic run_random(input int count, input bit triad, input bit hold_midway);
        logic [NUM_KEYS-1:0] held;
        logic [NUM_KEYS-1:0] keys;
        int                  k;
        held = '0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                keys = NUM_KEYS'({$urandom, $urandom});
            end else begin
                if ($urandom_range(0, 11) == 0) held = '0;
                repeat ($urandom_range(0, 2)) begin
                    k = $urandom_range(0, NUM_KEYS - 1);
                    held[k] = ~held[k];
                end
                if ($urandom_range(0, 5) == 0) held[KEY_CAPS] = ~held[KEY_CAPS];
                if ($urandom_range(0, 5) == 0) held[KEY_SYM] = ~held[KEY_SYM];
                keys = held;
            end
            if (triad && $urandom_range(0, 1) == 1) begin
                keys[KEY_CAPS] = 1'b1;
                keys[KEY_SYM]  = 1'b1;
                keys[KEY_BRK]  = 1'b1;
            end
            send_scan(keys);
            if (hold_midway && i == count / 2) settle();
        end
        settle();
    endtask

    initial begin : result_sink
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = pick_wait(out_run);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            tracker.compare_byte(o_kind, o_code, o_last);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        logic [NUM_KEYS-1:0] directed [$];
        logic [NUM_KEYS-1:0] raw_scans [$];
        directed = '{40'h00_0000_0000, 40'hFF_FFFF_FFFF, 40'h00_0000_0000,
                     40'h80_000F_801F, 40'h00_0000_0000, 40'h40_01FF_C3FF,
                     40'h00_0000_0000, 40'hC4_01FF_8010, 40'h00_0000_0000,
                     40'h3F_FE00_0000, 40'h3F_FE00_0000, 40'h40_0000_0000,
                     40'h00_0000_0010, 40'h80_0000_0010, 40'h80_0000_0010,
                     40'h00_0000_0000};
        raw_scans = '{40'hC0_0000_0010, 40'h40_0000_0010, 40'hFF_FFFF_FFFF,
                      40'h80_0000_0010, 40'h00_0000_0000};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_scan(directed[i]);
        settle();
        set_regs(7'd30, 7'd5, 1'b1);
        foreach (raw_scans[i]) send_scan(raw_scans[i]);
        settle();

        set_regs(7'd2, 7'd1, 1'b0);
        run_random(30, 1'b0, 1'b0);
        set_regs(7'd127, 7'd127, 1'b0);
        run_random(15, 1'b0, 1'b0);
        set_regs(7'd5, 7'd3, 1'b0);
        run_random(30, 1'b0, 1'b1);
        set_regs(7'($urandom_range(2, 127)), 7'($urandom_range(1, 127)), 1'b1);
        run_random(20, 1'b1, 1'b0);
        set_regs(7'd2, 7'd127, 1'b0);
        run_random(20, 1'b0, 1'b0);
        set_regs(7'($urandom_range(2, 12)), 7'($urandom_range(1, 6)), 1'b0);
        run_random(24, 1'b0, 1'b0);

        $display("Covered %0d scans under %0d register settings,", tracker.scans, settings);
        $display("all four keymap layers and raw mode, with %0d character bytes and %0d breaks.",
                 tracker.chars_seen, tracker.breaks_seen);
        if (tracker.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/kmae_pkg.sv
hdl/kmae_cell.sv
hdl/kmae_chain.sv
hdl/key_matrix_autorepeat_encoder_unit.sv
tb/tb_key_matrix_autorepeat_encoder_unit.sv
